[sv/accel_rep_counter_unit_macros.svh]
// Assertion macros shared by the rep counter RTL.
`ifndef ACCEL_REP_COUNTER_UNIT_MACROS_SVH
`define ACCEL_REP_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arc assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arc assertion failed: next-cycle check");

`endif

[sv/arc_pkg.sv]
// Types and constants for the repetition counter.
package arc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_UP   = 2'd2
    } t_phase;

    typedef logic signed [31:0] t_thr;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned GAP_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 2'd1;

    localparam logic [MODE_W-1:0] MODE_BENCH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHOULDER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURL     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_BENCH;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd1000;

    // Low-pass coefficient, 0.2 in Q0.16
    localparam logic signed [14:0] FILT_COEF = 15'sd13107;

    // Thresholds in Q.20 g
    localparam t_thr BENCH_LO    = 32'sd943718;
    localparam t_thr BENCH_HI    = 32'sd1205862;
    localparam t_thr BENCH_FIN   = 32'sd1101005;
    localparam t_thr SHLDR_LO    = 32'sd996147;
    localparam t_thr SHLDR_HI    = 32'sd1258291;
    localparam t_thr SHLDR_FIN   = 32'sd1153434;
    localparam t_thr CURL_UP     = 32'sd524288;
    localparam t_thr CURL_DOWN   = -32'sd314573;
    localparam t_thr CURL_FIN    = 32'sd209715;

endpackage

[sv/accel_rep_counter_unit.sv]
// The filter multiply and threshold compare fit one stage, between input and result registers.
// Throughput: one item per cycle unless the result stalls.
// A stalled result keeps the input register full and drops o_in_ready until the result drains.
// Reset (synchronous, active low): count, phase, last repetition time, filters cleared;
// exercise mode resets to bench, minimum gap to 1000 ms. No clearing pass.
`include "accel_rep_counter_unit_macros.svh"
module accel_rep_counter_unit
    import arc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_sample,
    input  logic [TIME_W-1:0]              i_time_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [COUNT_WIDTH-1:0]         o_rep_count,
    output logic                           o_rep_done,
    output logic [1:0]                     o_phase,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int FILT_W = SAMPLE_WIDTH + 8;

    // Configuration
    logic [MODE_W-1:0] r_mode;
    logic [GAP_W-1:0]  r_min_gap;

    // Input register
    logic                           r_in_valid;
    logic                           r_in_action;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic [TIME_W-1:0]              r_in_time;

    // Result register
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_done;
    t_phase                 r_out_phase;

    // Counter state
    t_phase                   r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]   r_count, n_count;
    logic [TIME_W-1:0]        r_last, n_last;
    logic signed [FILT_W-1:0] r_z, n_z;
    logic signed [FILT_W-1:0] r_y, n_y;
    logic                     n_done;

    logic                     adv;
    logic signed [FILT_W-1:0] filt_sel;
    logic signed [FILT_W-1:0] filt_new;
    t_thr                     filt_ext;
    t_thr                     thr_lo, thr_hi, thr_fin;
    logic                     gap_ok;
    logic                     cnt_max;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_min_gap <= GAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE: r_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_GAP:  r_min_gap <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_action <= i_action;
            r_in_sample <= i_accel_sample;
            r_in_time   <= i_time_ms;
        end
    end

    // The z filter serves bench and shoulder press, the y filter curl
    assign filt_sel = (r_mode == MODE_CURL) ? r_y : r_z;

    arc_filter #(
        .SAMPLE_W (SAMPLE_WIDTH)
    ) u_filter (
        .i_sample (r_in_sample),
        .i_filt   (filt_sel),
        .o_filt   (filt_new)
    );

    assign filt_ext = t_thr'(filt_new);
    assign gap_ok   = (r_in_time - r_last) > TIME_W'(r_min_gap);
    assign cnt_max  = &r_count;

    always_comb begin
        case (r_mode)
            MODE_SHOULDER: begin
                thr_lo  = SHLDR_LO;
                thr_hi  = SHLDR_HI;
                thr_fin = SHLDR_FIN;
            end
            default: begin
                thr_lo  = BENCH_LO;
                thr_hi  = BENCH_HI;
                thr_fin = BENCH_FIN;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_last  = r_last;
        n_z     = r_z;
        n_y     = r_y;
        n_done  = 1'b0;
        if (r_in_action) begin
            n_count = '0;
            n_phase = PH_IDLE;
        end else begin
            case (r_mode)
                MODE_BENCH, MODE_SHOULDER: begin
                    n_z = filt_new;
                    case (r_phase)
                        PH_DOWN: begin
                            if (filt_ext > thr_hi) n_phase = PH_UP;
                        end
                        PH_UP: begin
                            if (filt_ext > thr_fin) begin
                                n_done  = gap_ok;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = (filt_ext < thr_lo) ? PH_DOWN : PH_IDLE;
                        end
                    endcase
                end
                MODE_CURL: begin
                    n_y = filt_new;
                    case (r_phase)
                        PH_UP: begin
                            if (filt_ext < CURL_DOWN) n_phase = PH_DOWN;
                        end
                        PH_DOWN: begin
                            if (filt_ext > CURL_FIN) begin
                                n_done  = gap_ok;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = (filt_ext > CURL_UP) ? PH_UP : PH_IDLE;
                        end
                    endcase
                end
                default: ;
            endcase
            // Saturate the count, but still record the repetition time
            if (n_done) begin
                n_last = r_in_time;
                if (!cnt_max) n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_last  <= '0;
            r_z     <= '0;
            r_y     <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_last  <= n_last;
            r_z     <= n_z;
            r_y     <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_count <= n_count;
            r_out_done  <= n_done;
            r_out_phase <= n_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rep_count = r_out_count;
    assign o_rep_done  = r_out_done;
    assign o_phase     = r_out_phase;

    `ARC_ASSERT_NOW(a_done_ends_idle, i_clk, i_rst_n, r_out_valid && r_out_done,
        r_out_phase == PH_IDLE)
    `ARC_ASSERT_NOW(a_done_count_nonzero, i_clk, i_rst_n, r_out_valid && r_out_done,
        r_out_count != '0)
    `ARC_ASSERT_NEXT(a_reset_action, i_clk, i_rst_n, adv && r_in_action,
        r_out_valid && r_count == '0 && r_phase == PH_IDLE)
    `ARC_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, adv && !r_in_action,
        r_count >= $past(r_count))

endmodule

[sv/arc_filter.sv]
// One-pole low-pass update: filt + ((sample<<8 - filt) * 13107) >>> 16, a gain of 0.2.
module arc_filter
    import arc_pkg::*;
#(
    parameter int SAMPLE_W = 16
) (
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    input  logic signed [SAMPLE_W+7:0]   i_filt,
    output logic signed [SAMPLE_W+7:0]   o_filt
);

    localparam int FILT_W = SAMPLE_W + 8;
    localparam int DIFF_W = FILT_W + 1;
    localparam int PROD_W = FILT_W + 16;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [FILT_W-1:0] step;

    assign diff = DIFF_W'($signed({i_sample, 8'h00})) - DIFF_W'(i_filt);
    assign prod = PROD_W'(diff) * PROD_W'(FILT_COEF);
    // Drop 16 fraction bits: floor of the scaled difference
    assign step = $signed(prod[PROD_W-1:16]);
    assign o_filt = i_filt + step;

endmodule
